[rtl/eitp_pkg.sv]
// ----------------------------------------------------------------------------
// eitp_pkg
// Shared constants and types for the Ethernet/IPv4/TCP header parser.
// ----------------------------------------------------------------------------
package eitp_pkg;

  localparam int unsigned MaxFrameBytes = 2048;
  localparam int unsigned MaxOptions    = 6;
  localparam int unsigned PosW          = $clog2(MaxFrameBytes + 1);
  localparam int unsigned OptCntW       = $clog2(MaxOptions + 1);
  localparam int unsigned NumMethods    = 9;

  localparam logic [4:0] FC_DST_MAC   = 5'd0;
  localparam logic [4:0] FC_SRC_MAC   = 5'd1;
  localparam logic [4:0] FC_ETYPE     = 5'd2;
  localparam logic [4:0] FC_IP_VER    = 5'd3;
  localparam logic [4:0] FC_IP_HLEN   = 5'd4;
  localparam logic [4:0] FC_TOT_LEN   = 5'd5;
  localparam logic [4:0] FC_IP_ID     = 5'd6;
  localparam logic [4:0] FC_IP_FLAGS  = 5'd7;
  localparam logic [4:0] FC_FRAG_OFF  = 5'd8;
  localparam logic [4:0] FC_TTL       = 5'd9;
  localparam logic [4:0] FC_PROTO     = 5'd10;
  localparam logic [4:0] FC_IP_CSUM   = 5'd11;
  localparam logic [4:0] FC_SRC_IP    = 5'd12;
  localparam logic [4:0] FC_DST_IP    = 5'd13;
  localparam logic [4:0] FC_SRC_PORT  = 5'd14;
  localparam logic [4:0] FC_DST_PORT  = 5'd15;
  localparam logic [4:0] FC_SEQ       = 5'd16;
  localparam logic [4:0] FC_ACK       = 5'd17;
  localparam logic [4:0] FC_TCP_HLEN  = 5'd18;
  localparam logic [4:0] FC_TCP_FLAGS = 5'd19;
  localparam logic [4:0] FC_WINDOW    = 5'd20;
  localparam logic [4:0] FC_TCP_CSUM  = 5'd21;
  localparam logic [4:0] FC_URGENT    = 5'd22;
  localparam logic [4:0] FC_OPT_KIND  = 5'd23;
  localparam logic [4:0] FC_MSS       = 5'd24;
  localparam logic [4:0] FC_WSCALE    = 5'd25;
  localparam logic [4:0] FC_TS_VAL    = 5'd26;
  localparam logic [4:0] FC_TS_ECR    = 5'd27;
  localparam logic [4:0] FC_METHOD    = 5'd28;
  localparam logic [4:0] FC_FRAME_END = 5'd29;

  localparam logic [7:0] OPT_NOP    = 8'd1;
  localparam logic [7:0] OPT_MSS    = 8'd2;
  localparam logic [7:0] OPT_WSCALE = 8'd3;
  localparam logic [7:0] OPT_SACKOK = 8'd4;
  localparam logic [7:0] OPT_TS     = 8'd8;

  // One parsed result.
  typedef struct packed {
    logic [4:0]  code;
    logic [47:0] value;
    logic [1:0]  depth;
    logic        last;
  } result_t;

  // What the front end hands the back end for one byte: up to two results.
  typedef struct packed {
    logic    v0;
    result_t r0;
    logic    v1;
    result_t r1;
  } work_t;

  // Method text, byte q of candidate k; zero past the name's end.
  function automatic logic [7:0] method_char(input logic [3:0] k, input logic [2:0] q);
    logic [55:0] s;
    begin
      unique case (k)
        4'd0:    s = {"GET", 32'h0};
        4'd1:    s = {"HEAD", 24'h0};
        4'd2:    s = {"POST", 24'h0};
        4'd3:    s = {"PUT", 32'h0};
        4'd4:    s = {"DELETE", 8'h0};
        4'd5:    s = "CONNECT";
        4'd6:    s = "OPTIONS";
        4'd7:    s = {"TRACE", 16'h0};
        4'd8:    s = {"PATCH", 16'h0};
        default: s = '0;
      endcase
      method_char = s[55 - 8*q -: 8];
    end
  endfunction

  function automatic logic [2:0] method_len(input logic [3:0] k);
    begin
      unique case (k)
        4'd0, 4'd3:       method_len = 3'd3;
        4'd1, 4'd2:       method_len = 3'd4;
        4'd4:             method_len = 3'd6;
        4'd5, 4'd6:       method_len = 3'd7;
        4'd7, 4'd8:       method_len = 3'd5;
        default:          method_len = 3'd0;
      endcase
    end
  endfunction

endpackage

[rtl/eitp_if.sv]
// ----------------------------------------------------------------------------
// eitp_in_if / eitp_out_if
// Valid/ready channels for frame bytes and parsed results.
// ----------------------------------------------------------------------------
interface eitp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface eitp_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  field_code;
  logic [47:0] field_value;
  logic [1:0]  end_depth;
  logic        last_result;
  modport source (output valid, output field_code, output field_value,
                  output end_depth, output last_result, input ready);
  modport sink (input valid, input field_code, input field_value,
                input end_depth, input last_result, output ready);
endinterface

[rtl/eth_ipv4_tcp_header_parser.sv]
// ----------------------------------------------------------------------------
// eth_ipv4_tcp_header_parser
// Streams Ethernet/IPv4/TCP header fields, TCP options and HTTP method.
// ----------------------------------------------------------------------------
// A field result is written into the four-entry queue when its last byte
// is accepted and is sent from the queue head. Throughput: one byte per
// cycle while the queue has room; two results of one byte leave in turn.
// Reset clears the parser state and empties the queue.
module eth_ipv4_tcp_header_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  eitp_in_if.sink     in,
  eitp_out_if.source  out
);

  eitp_pkg::work_t work;
  logic            full, take;

  // A byte is taken whenever the queue has room.
  assign in.ready = !full;
  assign take     = in.valid && !full;

  eitp_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .byte_i (in.data_byte),
    .last_i (in.last_byte),
    .work_o (work)
  );

  eitp_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (take),
    .work_i (work),
    .full_o (full),
    .out    (out)
  );

endmodule

[rtl/eitp_front.sv]
// ----------------------------------------------------------------------------
// eitp_front
// Byte parser: tracks position and header lengths, produces per-byte results.
// ----------------------------------------------------------------------------
module eitp_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 take_i,
  input  logic [7:0]           byte_i,
  input  logic                 last_i,
  output eitp_pkg::work_t      work_o
);

  logic [eitp_pkg::PosW-1:0]    pos_q, pos_d;
  logic [47:0]                  acc_q, acc_d;
  logic [5:0]                   iphl_q, iphl_d;
  logic [5:0]                   tcphl_q, tcphl_d;
  logic [3:0]                   ophase_q, ophase_d;
  logic [eitp_pkg::OptCntW-1:0] ocnt_q, ocnt_d;
  logic                         ostop_q, ostop_d;
  logic [eitp_pkg::NumMethods-1:0] mmask_q, mmask_d;
  logic [1:0]                   depth_q, depth_d;

  eitp_pkg::result_t r0, r1;
  logic              v0, v1;
  logic              in_range;
  logic [7:0]        b;
  logic [5:0]        raw_ip, raw_tcp;
  logic [eitp_pkg::PosW-1:0] p, t, r, pos_inc;
  logic [2:0]        q;
  logic [3:0]        mval;
  logic [eitp_pkg::NumMethods-1:0] mnew;

  always_comb begin
    b        = byte_i;
    p        = pos_q;
    in_range = pos_q < eitp_pkg::PosW'(eitp_pkg::MaxFrameBytes);
    acc_d    = {acc_q[39:0], b};
    pos_d = pos_q; iphl_d = iphl_q; tcphl_d = tcphl_q; ophase_d = ophase_q;
    ocnt_d = ocnt_q; ostop_d = ostop_q; mmask_d = mmask_q; depth_d = depth_q;
    v0 = 1'b0; v1 = 1'b0;
    r0 = '0; r1 = '0;
    raw_ip  = {b[3:0], 2'b00};
    raw_tcp = {b[7:4], 2'b00};
    t = eitp_pkg::PosW'(14) + eitp_pkg::PosW'(iphl_q);
    r = p - t;
    q = 3'(r - eitp_pkg::PosW'(tcphl_q));
    mnew = mmask_q;
    mval = 4'd0;
    pos_inc = pos_q + 1'b1;

    if (in_range) begin
      pos_d = pos_inc;
      v0 = 1'b1;
      unique case (p)
        eitp_pkg::PosW'(5):  r0 = '{eitp_pkg::FC_DST_MAC, acc_d, 2'd0, 1'b0};
        eitp_pkg::PosW'(11): r0 = '{eitp_pkg::FC_SRC_MAC, acc_d, 2'd0, 1'b0};
        eitp_pkg::PosW'(13): begin
          r0 = '{eitp_pkg::FC_ETYPE, {32'd0, acc_d[15:0]}, 2'd0, 1'b0};
          depth_d = 2'd1;
        end
        eitp_pkg::PosW'(14): begin
          r0 = '{eitp_pkg::FC_IP_VER, {44'd0, b[7:4]}, 2'd0, 1'b0};
          v1 = 1'b1;
          r1 = '{eitp_pkg::FC_IP_HLEN, {42'd0, raw_ip}, 2'd0, 1'b0};
          iphl_d = (raw_ip < 6'd20) ? 6'd20 : raw_ip;
        end
        eitp_pkg::PosW'(17): r0 = '{eitp_pkg::FC_TOT_LEN, {32'd0, acc_d[15:0]}, 2'd0, 1'b0};
        eitp_pkg::PosW'(19): r0 = '{eitp_pkg::FC_IP_ID, {32'd0, acc_d[15:0]}, 2'd0, 1'b0};
        eitp_pkg::PosW'(20): r0 = '{eitp_pkg::FC_IP_FLAGS, {45'd0, b[7:5]}, 2'd0, 1'b0};
        eitp_pkg::PosW'(21): r0 = '{eitp_pkg::FC_FRAG_OFF, {35'd0, acc_d[12:0]}, 2'd0, 1'b0};
        eitp_pkg::PosW'(22): r0 = '{eitp_pkg::FC_TTL, {40'd0, b}, 2'd0, 1'b0};
        eitp_pkg::PosW'(23): r0 = '{eitp_pkg::FC_PROTO, {40'd0, b}, 2'd0, 1'b0};
        eitp_pkg::PosW'(25): r0 = '{eitp_pkg::FC_IP_CSUM, {32'd0, acc_d[15:0]}, 2'd0, 1'b0};
        eitp_pkg::PosW'(29): r0 = '{eitp_pkg::FC_SRC_IP, {16'd0, acc_d[31:0]}, 2'd0, 1'b0};
        eitp_pkg::PosW'(33): r0 = '{eitp_pkg::FC_DST_IP, {16'd0, acc_d[31:0]}, 2'd0, 1'b0};
        default: v0 = 1'b0;
      endcase
      // Transport part starts after the IP header (which is >= 20, so no overlap
      // with the fixed IP fields above).
      if (p == eitp_pkg::PosW'(13) + eitp_pkg::PosW'(iphl_q) && depth_q < 2'd2)
        depth_d = 2'd2;
      if (p >= t && p != eitp_pkg::PosW'(14)) begin
        v0 = 1'b1;
        priority case (r)
          eitp_pkg::PosW'(1):  r0 = '{eitp_pkg::FC_SRC_PORT, {32'd0, acc_d[15:0]}, 2'd0, 1'b0};
          eitp_pkg::PosW'(3):  r0 = '{eitp_pkg::FC_DST_PORT, {32'd0, acc_d[15:0]}, 2'd0, 1'b0};
          eitp_pkg::PosW'(7):  r0 = '{eitp_pkg::FC_SEQ, {16'd0, acc_d[31:0]}, 2'd0, 1'b0};
          eitp_pkg::PosW'(11): r0 = '{eitp_pkg::FC_ACK, {16'd0, acc_d[31:0]}, 2'd0, 1'b0};
          eitp_pkg::PosW'(12): begin
            r0 = '{eitp_pkg::FC_TCP_HLEN, {42'd0, raw_tcp}, 2'd0, 1'b0};
            tcphl_d = (raw_tcp < 6'd20) ? 6'd20 : raw_tcp;
          end
          eitp_pkg::PosW'(13): r0 = '{eitp_pkg::FC_TCP_FLAGS, {42'd0, b[5:0]}, 2'd0, 1'b0};
          eitp_pkg::PosW'(15): r0 = '{eitp_pkg::FC_WINDOW, {32'd0, acc_d[15:0]}, 2'd0, 1'b0};
          eitp_pkg::PosW'(17): r0 = '{eitp_pkg::FC_TCP_CSUM, {32'd0, acc_d[15:0]}, 2'd0, 1'b0};
          eitp_pkg::PosW'(19): r0 = '{eitp_pkg::FC_URGENT, {32'd0, acc_d[15:0]}, 2'd0, 1'b0};
          default: v0 = 1'b0;
        endcase
        // TCP options: at most one result per byte, none of the fixed fields.
        if (r >= eitp_pkg::PosW'(20) && r < eitp_pkg::PosW'(tcphl_q) && !ostop_q) begin
          unique case (ophase_q)
            4'd0: begin
              if (ocnt_q >= eitp_pkg::OptCntW'(eitp_pkg::MaxOptions)) begin
                ostop_d = 1'b1;
              end else if (b == eitp_pkg::OPT_NOP || b == eitp_pkg::OPT_MSS ||
                           b == eitp_pkg::OPT_WSCALE || b == eitp_pkg::OPT_SACKOK ||
                           b == eitp_pkg::OPT_TS) begin
                v0 = 1'b1;
                r0 = '{eitp_pkg::FC_OPT_KIND, {40'd0, b}, 2'd0, 1'b0};
                ocnt_d = ocnt_q + 1'b1;
                if (b == eitp_pkg::OPT_MSS) ophase_d = 4'd1;
                else if (b == eitp_pkg::OPT_WSCALE) ophase_d = 4'd4;
                else if (b == eitp_pkg::OPT_SACKOK) ophase_d = 4'd6;
                else if (b == eitp_pkg::OPT_TS) ophase_d = 4'd7;
              end else begin
                ostop_d = 1'b1;
              end
            end
            4'd3: begin
              v0 = 1'b1;
              r0 = '{eitp_pkg::FC_MSS, {32'd0, acc_d[15:0]}, 2'd0, 1'b0};
              ophase_d = 4'd0;
            end
            4'd5: begin
              v0 = 1'b1;
              r0 = '{eitp_pkg::FC_WSCALE, {40'd0, b}, 2'd0, 1'b0};
              ophase_d = 4'd0;
            end
            4'd6: ophase_d = 4'd0;
            4'd11: begin
              v0 = 1'b1;
              r0 = '{eitp_pkg::FC_TS_VAL, {16'd0, acc_d[31:0]}, 2'd0, 1'b0};
              ophase_d = 4'd12;
            end
            4'd15: begin
              v0 = 1'b1;
              r0 = '{eitp_pkg::FC_TS_ECR, {16'd0, acc_d[31:0]}, 2'd0, 1'b0};
              ophase_d = 4'd0;
            end
            default: ophase_d = ophase_q + 1'b1;
          endcase
        end
        if (r + 1'b1 == eitp_pkg::PosW'(tcphl_q)) depth_d = 2'd3;
        if (r >= eitp_pkg::PosW'(tcphl_q) &&
            r - eitp_pkg::PosW'(tcphl_q) < eitp_pkg::PosW'(7)) begin
          for (int k = 0; k < eitp_pkg::NumMethods; k++) begin
            if (q < eitp_pkg::method_len(4'(k)) && b != eitp_pkg::method_char(4'(k), q))
              mnew[k] = 1'b0;
          end
          mmask_d = mnew;
          if (q == 3'd6) begin
            for (int k = eitp_pkg::NumMethods - 1; k >= 0; k--) begin
              if (mnew[k]) mval = 4'(k + 1);
            end
            v0 = 1'b1;
            r0 = '{eitp_pkg::FC_METHOD, {44'd0, mval}, 2'd0, 1'b0};
          end
        end
      end
    end

    if (last_i) begin
      // Frame end: keeps at most the first per-byte result.
      v1 = 1'b1;
      r1 = '{eitp_pkg::FC_FRAME_END, {{(48 - eitp_pkg::PosW){1'b0}}, pos_d},
             depth_d, 1'b1};
      pos_d = '0; iphl_d = 6'd20; tcphl_d = 6'd20; ophase_d = 4'd0;
      ocnt_d = '0; ostop_d = 1'b0; mmask_d = '1; depth_d = 2'd0; acc_d = '0;
    end
    if (!in_range) acc_d = last_i ? '0 : acc_q;

    work_o = '{v0, r0, v1, r1};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; acc_q <= '0; iphl_q <= 6'd20; tcphl_q <= 6'd20;
      ophase_q <= 4'd0; ocnt_q <= '0; ostop_q <= 1'b0; mmask_q <= '1;
      depth_q <= 2'd0;
    end else if (take_i) begin
      pos_q <= pos_d; acc_q <= acc_d; iphl_q <= iphl_d; tcphl_q <= tcphl_d;
      ophase_q <= ophase_d; ocnt_q <= ocnt_d; ostop_q <= ostop_d;
      mmask_q <= mmask_d; depth_q <= depth_d;
    end
  end

endmodule

[rtl/eitp_back.sv]
// ----------------------------------------------------------------------------
// eitp_back
// Work queue and output stage: streams out up to two results per entry.
// ----------------------------------------------------------------------------
module eitp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  eitp_pkg::work_t   work_i,
  output logic              full_o,
  eitp_out_if.source        out
);

  localparam int unsigned Depth = 4;

  eitp_pkg::work_t mem_q [Depth];
  logic [1:0] wp_q, wp_d, rp_q, rp_d;
  logic [2:0] cnt_q, cnt_d;
  logic       half_q, half_d;
  eitp_pkg::work_t head;
  eitp_pkg::result_t cur;
  logic cur_v, pop, adv, fire, do_push;

  always_comb begin
    head = mem_q[rp_q];
    cur_v = 1'b0;
    cur = head.r0;
    if (cnt_q != 3'd0) begin
      if (!half_q && head.v0) begin
        cur_v = 1'b1; cur = head.r0;
      end else if (head.v1) begin
        cur_v = 1'b1; cur = head.r1;
      end
    end
    fire = cur_v && out.ready;
    // Entry is done when its final result leaves or it has none left.
    adv = (cnt_q != 3'd0) && (!cur_v || (fire && (half_q || !head.v0 || !head.v1)));
    pop = adv;
    half_d = half_q;
    if (pop) half_d = 1'b0;
    else if (fire) half_d = 1'b1;
    do_push = push_i && (work_i.v0 || work_i.v1);
    wp_d = do_push ? wp_q + 1'b1 : wp_q;
    rp_d = pop ? rp_q + 1'b1 : rp_q;
    cnt_d = cnt_q + {2'd0, do_push} - {2'd0, pop};
    full_o = cnt_q == 3'(Depth);
  end

  assign out.valid       = cur_v;
  assign out.field_code  = cur.code;
  assign out.field_value = cur.value;
  assign out.end_depth   = cur.depth;
  assign out.last_result = cur.last;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wp_q] <= work_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0; half_q <= 1'b0;
    end else begin
      wp_q <= wp_d; rp_q <= rp_d; cnt_q <= cnt_d; half_q <= half_d;
    end
  end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Frame-level test of the Ethernet/IPv4/TCP header parser. Directed frames
// cover short and truncated frames, short header lengths, every option kind,
// every HTTP method and an oversized frame. Random frames follow. A parse
// scoreboard predicts every field result from the accepted bytes and checks
// the result stream in order.
// ----------------------------------------------------------------------------
module tb;
  import eitp_pkg::*;

  // Parser state mirror plus the queue of results still owed by the block.
  class parse_scoreboard;
    int unsigned pos;
    logic [47:0] acc;
    int unsigned ip_len;
    int unsigned tcp_len;
    logic [3:0]  opt_phase;
    int unsigned opt_cnt;
    bit          opt_stop;
    logic [8:0]  cand;
    logic [1:0]  depth;
    result_t     step_res[$];
    result_t     owed[$];
    string       names[9];

    function new();
      names = '{"GET", "HEAD", "POST", "PUT", "DELETE", "CONNECT", "OPTIONS",
                "TRACE", "PATCH"};
      restart();
    endfunction

    function void restart();
      pos = 0;
      acc = '0;
      ip_len = 20;
      tcp_len = 20;
      opt_phase = '0;
      opt_cnt = 0;
      opt_stop = 0;
      cand = '1;
      depth = '0;
    endfunction

    function void put(logic [4:0] code, logic [47:0] value);
      result_t r;
      r.code = code;
      r.value = value;
      r.depth = '0;
      r.last = 1'b0;
      step_res.push_back(r);
    endfunction

    function void option_step(logic [7:0] b);
      case (opt_phase)
        4'd0: begin
          if (opt_cnt >= MaxOptions) begin
            opt_stop = 1;
          end else if (b == OPT_NOP || b == OPT_MSS || b == OPT_WSCALE ||
                       b == OPT_SACKOK || b == OPT_TS) begin
            put(FC_OPT_KIND, {40'd0, b});
            opt_cnt++;
            if (b == OPT_MSS) opt_phase = 4'd1;
            else if (b == OPT_WSCALE) opt_phase = 4'd4;
            else if (b == OPT_SACKOK) opt_phase = 4'd6;
            else if (b == OPT_TS) opt_phase = 4'd7;
          end else begin
            opt_stop = 1;
          end
        end
        4'd3: begin
          put(FC_MSS, {32'd0, acc[15:0]});
          opt_phase = 4'd0;
        end
        4'd5: begin
          put(FC_WSCALE, {40'd0, b});
          opt_phase = 4'd0;
        end
        4'd6: opt_phase = 4'd0;
        4'd11: begin
          put(FC_TS_VAL, {16'd0, acc[31:0]});
          opt_phase = 4'd12;
        end
        4'd15: begin
          put(FC_TS_ECR, {16'd0, acc[31:0]});
          opt_phase = 4'd0;
        end
        default: opt_phase = opt_phase + 4'd1;
      endcase
    endfunction

    function void method_step(int unsigned q, logic [7:0] b);
      int unsigned found;
      found = 0;
      for (int k = 0; k < 9; k++)
        if (q < names[k].len() && b != names[k][q]) cand[k] = 1'b0;
      if (q == 6) begin
        for (int k = 8; k >= 0; k--)
          if (cand[k]) found = k + 1;
        put(FC_METHOD, 48'(found));
      end
    endfunction

    function void parse(int unsigned p, logic [7:0] b);
      int unsigned t, raw, r;
      t = 14 + ip_len;
      case (p)
        5: put(FC_DST_MAC, acc);
        11: put(FC_SRC_MAC, acc);
        13: begin
          put(FC_ETYPE, {32'd0, acc[15:0]});
          depth = 2'd1;
        end
        14: begin
          raw = b[3:0] * 4;
          put(FC_IP_VER, {44'd0, b[7:4]});
          put(FC_IP_HLEN, 48'(raw));
          ip_len = raw < 20 ? 20 : raw;
          t = 14 + ip_len;
        end
        17: put(FC_TOT_LEN, {32'd0, acc[15:0]});
        19: put(FC_IP_ID, {32'd0, acc[15:0]});
        20: put(FC_IP_FLAGS, {45'd0, b[7:5]});
        21: put(FC_FRAG_OFF, {35'd0, acc[12:0]});
        22: put(FC_TTL, {40'd0, b});
        23: put(FC_PROTO, {40'd0, b});
        25: put(FC_IP_CSUM, {32'd0, acc[15:0]});
        29: put(FC_SRC_IP, {16'd0, acc[31:0]});
        33: put(FC_DST_IP, {16'd0, acc[31:0]});
        default: ;
      endcase
      if (p == 13 + ip_len && depth < 2) depth = 2'd2;
      if (p < t) return;
      r = p - t;
      case (r)
        1: put(FC_SRC_PORT, {32'd0, acc[15:0]});
        3: put(FC_DST_PORT, {32'd0, acc[15:0]});
        7: put(FC_SEQ, {16'd0, acc[31:0]});
        11: put(FC_ACK, {16'd0, acc[31:0]});
        12: begin
          raw = b[7:4] * 4;
          put(FC_TCP_HLEN, 48'(raw));
          tcp_len = raw < 20 ? 20 : raw;
        end
        13: put(FC_TCP_FLAGS, {42'd0, b[5:0]});
        15: put(FC_WINDOW, {32'd0, acc[15:0]});
        17: put(FC_TCP_CSUM, {32'd0, acc[15:0]});
        19: put(FC_URGENT, {32'd0, acc[15:0]});
        default: ;
      endcase
      if (r >= 20 && r < tcp_len && !opt_stop) option_step(b);
      if (r + 1 == tcp_len) depth = 2'd3;
      if (r >= tcp_len && r - tcp_len < 7) method_step(r - tcp_len, b);
    endfunction

    // Called for every accepted frame byte.
    function void note_byte(logic [7:0] b, logic last);
      result_t fe;
      step_res.delete();
      if (pos < MaxFrameBytes) begin
        acc = {acc[39:0], b};
        parse(pos, b);
        pos++;
      end
      if (last) begin
        // On the final byte only the first field result survives.
        while (step_res.size() > 1) void'(step_res.pop_back());
        fe.code = FC_FRAME_END;
        fe.value = 48'(pos);
        fe.depth = depth;
        fe.last = 1'b1;
        step_res.push_back(fe);
        restart();
      end
      foreach (step_res[i]) owed.push_back(step_res[i]);
    endfunction

    // Returns an empty string when the result matches the oldest expectation.
    function string check_result(result_t got);
      result_t want;
      if (owed.size() == 0)
        return $sformatf("unexpected result code %0d value %0h", got.code, got.value);
      want = owed.pop_front();
      if (got.code !== want.code || got.value !== want.value ||
          got.depth !== want.depth || got.last !== want.last)
        return $sformatf("got code %0d value %0h depth %0d last %0b, want %0d %0h %0d %0b",
                         got.code, got.value, got.depth, got.last,
                         want.code, want.value, want.depth, want.last);
      return "";
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  eitp_in_if  in_if ();
  eitp_out_if out_if ();

  eth_ipv4_tcp_header_parser dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in     (in_if.sink),
    .out    (out_if.source)
  );

  parse_scoreboard sb = new();
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned bytes_sent = 0;
  int unsigned frames_sent = 0;
  int unsigned cycle = 0;
  int unsigned quiet = 0;
  localparam int unsigned QuietLimit = 3000;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // No idling at all between cycles 2000 and 3500.
  function automatic bit take_break();
    if (cycle >= 2000 && cycle < 3500) return 0;
    return $urandom_range(99) < 11;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  initial begin
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Result sink with random stalls; held off while in reset.
  always @(posedge clk_i) begin
    out_if.ready <= (rst_ni === 1'b1) ? !take_break() : 1'b0;
  end

  // Acceptance monitor: both sides are sampled at the edge, before any update.
  always @(posedge clk_i) begin
    result_t got;
    string msg;
    cycle++;
    quiet++;
    if (in_if.valid && in_if.ready) begin
      sb.note_byte(in_if.data_byte, in_if.last_byte);
      quiet = 0;
    end
    if (out_if.valid && out_if.ready) begin
      got.code = out_if.field_code;
      got.value = out_if.field_value;
      got.depth = out_if.end_depth;
      got.last = out_if.last_result;
      msg = sb.check_result(got);
      if (msg != "") report_mismatch(msg);
      results_seen++;
      quiet = 0;
    end
    if (quiet >= QuietLimit) begin
      $display("watchdog: no request moved for %0d cycles", QuietLimit);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Drives one frame, one request per byte, with random gaps.
  task automatic send_frame(input logic [7:0] fb[$]);
    foreach (fb[i]) begin
      while (take_break()) begin
        in_if.valid <= 1'b0;
        @(posedge clk_i);
      end
      in_if.valid <= 1'b1;
      in_if.data_byte <= fb[i];
      in_if.last_byte <= (i == fb.size() - 1);
      do @(posedge clk_i); while (!in_if.ready);
      bytes_sent++;
    end
    in_if.valid <= 1'b0;
    frames_sent++;
  endtask

  // Fills a TCP option area, mostly with well-formed options.
  function automatic void add_options(ref logic [7:0] fb[$], input int unsigned room,
                                      input bit clean);
    logic [7:0] kind;
    int unsigned olen, pick;
    while (room > 0) begin
      pick = $urandom_range(clean ? 9 : 11);
      case (pick)
        0, 1: kind = OPT_NOP;
        2, 3: kind = OPT_MSS;
        4, 5: kind = OPT_WSCALE;
        6:    kind = OPT_SACKOK;
        7, 8, 9: kind = OPT_TS;
        10:   kind = 8'd0;
        default: kind = 8'($urandom_range(255));
      endcase
      olen = (kind == OPT_MSS) ? 4 : (kind == OPT_WSCALE) ? 3 :
             (kind == OPT_SACKOK) ? 2 : (kind == OPT_TS) ? 10 : 1;
      if (olen > room) begin
        repeat (room) fb.push_back(8'($urandom_range(255)));
        room = 0;
      end else begin
        fb.push_back(kind);
        if (olen > 1) fb.push_back(8'(olen));
        repeat (olen > 2 ? olen - 2 : 0) fb.push_back(8'($urandom_range(255)));
        room -= olen;
      end
    end
  endfunction

  // Builds a frame; a method index of 9 or more gives random payload text.
  function automatic void build_frame(ref logic [7:0] fb[$], input int unsigned ihl,
                                      input int unsigned doff, input int unsigned meth,
                                      input int unsigned extra, input bit clean);
    string names[9] = '{"GET", "HEAD", "POST", "PUT", "DELETE", "CONNECT",
                        "OPTIONS", "TRACE", "PATCH"};
    int unsigned iplen, tcplen;
    fb.delete();
    repeat (14) fb.push_back(8'($urandom_range(255)));
    iplen = ihl * 4 < 20 ? 20 : ihl * 4;
    tcplen = doff * 4 < 20 ? 20 : doff * 4;
    fb.push_back({($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'd4, 4'(ihl)});
    repeat (iplen - 1) fb.push_back(8'($urandom_range(255)));
    repeat (12) fb.push_back(8'($urandom_range(255)));
    fb.push_back({4'(doff), 4'($urandom_range(15))});
    repeat (7) fb.push_back(8'($urandom_range(255)));
    add_options(fb, tcplen - 20, clean);
    if (meth < 9) begin
      for (int j = 0; j < names[meth].len(); j++) fb.push_back(names[meth][j]);
      // Sometimes spoil the last letter so that no candidate survives.
      if ($urandom_range(7) == 0) fb[fb.size() - 1] = 8'($urandom_range(255));
    end
    repeat (extra) fb.push_back(8'($urandom_range(255)));
  endfunction

  initial begin
    logic [7:0] fb[$];
    int unsigned ihl, doff, cut;

    in_if.valid = 1'b0;
    in_if.data_byte = '0;
    in_if.last_byte = 1'b0;

    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    // Directed: one-byte frame, a frame that ends inside the MAC header and
    // one that ends on the version byte.
    fb = '{8'hff};
    send_frame(fb);
    fb = '{8'h00, 8'hff, 8'h00, 8'hff, 8'h00, 8'hff, 8'h00, 8'hff};
    send_frame(fb);
    build_frame(fb, 5, 5, 9, 0, 1);
    fb = fb[0:14];
    send_frame(fb);

    // Short header lengths on both layers, and maximum lengths with options.
    build_frame(fb, 0, 2, 1, 4, 1);
    send_frame(fb);
    build_frame(fb, 15, 15, 6, 3, 1);
    send_frame(fb);
    build_frame(fb, 5, 15, 0, 7, 0);
    send_frame(fb);

    // Every method, then a frame far past the parse limit.
    for (int m = 0; m < 9; m++) begin
      build_frame(fb, 5 + $urandom_range(2), 5 + $urandom_range(5), m,
                  $urandom_range(4), 1);
      send_frame(fb);
    end
    build_frame(fb, 5, 8, 0, 0, 1);
    while (fb.size() < MaxFrameBytes + 20) fb.push_back(8'($urandom_range(255)));
    send_frame(fb);

    // Random frames: mostly well formed, some with broken lengths or options,
    // some cut short anywhere.
    while (bytes_sent < MaxFrameBytes + 800) begin
      ihl = ($urandom_range(3) == 0) ? $urandom_range(15) : 5 + $urandom_range(3);
      doff = ($urandom_range(4) == 0) ? $urandom_range(15) : 5 + $urandom_range(10);
      build_frame(fb, ihl, doff, $urandom_range(11), $urandom_range(12),
                  $urandom_range(4) != 0);
      if ($urandom_range(5) == 0) begin
        cut = 1 + $urandom_range(fb.size() - 1);
        fb = fb[0:cut - 1];
      end
      send_frame(fb);
    end

    // Drain, then keep watching for any stray result before the final check.
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.owed.size() != 0) report_mismatch("results still owed at the end");

    $display("Sent %0d bytes in %0d frames, checked %0d results.",
             bytes_sent, frames_sent, results_seen);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
